// ===== sv/kwm_pkg.sv =====
package kwm_pkg;

    localparam int MAX_RUNS   = 8;
    localparam int RUN_W      = 3;
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 48;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = $clog2(MAX_RUNS + 1);
    localparam int SCAN_W     = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RESET_RUNS = (8 < MAX_RUNS) ? 8 : MAX_RUNS;

    // Candidate handed from cell to cell during the max search
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [RUN_W-1:0] run;
    } cand_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic restart;  // drop the head
        logic arm;      // awaiting value to take on restart
        logic load;     // accepted transaction for this run
        logic take;     // head was emitted; wait for a refill
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/kwm_cell.sv =====
module kwm_cell
    import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RUN_W-1:0] run_id,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] key,
    input  logic [TAG_W-1:0] tag,
    input  logic             run_done,
    input  cand_t            cand_in,
    output cand_t            cand_out,
    output logic             awaiting
);

    logic             valid_reg;
    logic             await_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TAG_W-1:0] tag_reg;
    cand_t            cand_reg;
    cand_t            cand_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            await_reg <= 1'b1;
        end
        else if (ctl.restart)
        begin
            valid_reg <= 1'b0;
            await_reg <= ctl.arm;
        end
        else if (ctl.load)
        begin
            await_reg <= 1'b0;
            if (!run_done)
            begin
                valid_reg <= 1'b1;
            end
        end
        else if (ctl.take)
        begin
            valid_reg <= 1'b0;
            await_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && !run_done)
        begin
            key_reg <= key;
            tag_reg <= tag;
        end
    end

    // Keep the incoming candidate on ties: it comes from a lower run
    always_comb
    begin
        cand_next = cand_in;
        if (valid_reg && (!cand_in.valid || key_reg > cand_in.key))
        begin
            cand_next.valid = 1'b1;
            cand_next.key   = key_reg;
            cand_next.tag   = tag_reg;
            cand_next.run   = run_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;
    assign awaiting = await_reg;

endmodule

// ===== sv/kway_merge_max_first.sv =====
// K-way merge of runs sorted in descending key order.
// Input channel (in_valid/in_ready): each transaction carries the next element
// of a run, or run_done for an exhausted run. Transactions for runs that are
// not awaited, or not below active_runs, are accepted and dropped.
// Output channel (out_valid/out_ready): the largest head with its run, ties to
// the lowest run; from_run is the run to refill next. When all runs are
// exhausted one transaction with merge_done set and zero fields follows.
// Config channel (cfg_valid/cfg_ready): writes active_runs (0 reads as 1,
// above 8 as 8) and restarts the merge; write only while idle.
// Timing: the transaction that clears the last awaited run starts a search
// that walks the row of run cells, one cell per cycle, and then loads the
// output register; other inputs are accepted without starting a search.
// in_ready is high only in idle, not during a search or while a finished
// result waits; it stays high while a result sits in the output register.
// A stalled receiver holds the finished result in the search's last step
// until the output register frees up.
// Reset: all heads empty, 8 runs active and awaited, output empty.
module kway_merge_max_first
    import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RUN_W-1:0] run_index,
    input  logic [KEY_W-1:0] key,
    input  logic [TAG_W-1:0] tag,
    input  logic             run_done,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KEY_W-1:0] out_key,
    output logic [TAG_W-1:0] out_tag,
    output logic [RUN_W-1:0] from_run,
    output logic             merge_done,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] active_runs
);

    state_t            state_reg;
    state_t            state_next;
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic [SCAN_W-1:0] scan_cnt_next;
    logic [CNT_W-1:0]  runs_reg;
    logic [CNT_W-1:0]  runs_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KEY_W-1:0]  out_key_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [RUN_W-1:0]  from_run_reg;
    logic              merge_done_reg;

    logic                cfg_fire;
    logic                in_fire;
    logic                go_scan;
    logic                emit_fire;
    logic [MAX_RUNS-1:0] cell_await;
    logic [MAX_RUNS-1:0] awaiting;
    logic [MAX_RUNS-1:0] load_vec;
    cell_ctl_t           ctl [MAX_RUNS];
    cand_t               chain [MAX_RUNS+1];
    cand_t               best;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign best      = chain[MAX_RUNS];
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Clamp the written run count into 1..MAX_RUNS
    always_comb
    begin
        if (active_runs == '0)
        begin
            runs_next = CNT_W'(1);
        end
        else if (32'(active_runs) > MAX_RUNS)
        begin
            runs_next = CNT_W'(MAX_RUNS);
        end
        else
        begin
            runs_next = CNT_W'(active_runs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runs_reg <= CNT_W'(RESET_RUNS);
        end
        else if (cfg_fire)
        begin
            runs_reg <= runs_next;
        end
    end

    assign chain[0] = '0;

    genvar i;
    generate
        for (i = 0; i < MAX_RUNS; i++)
        begin : g_cell
            assign awaiting[i] = cell_await[i] && (32'(runs_reg) > i);
            assign load_vec[i] = in_fire && (32'(run_index) == i) && awaiting[i];

            always_comb
            begin
                ctl[i].restart = cfg_fire;
                ctl[i].arm     = (32'(runs_next) > i);
                ctl[i].load    = load_vec[i];
                ctl[i].take    = emit_fire && best.valid && (32'(best.run) == i);
            end

            kwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .run_id   (RUN_W'(i)),
                .ctl      (ctl[i]),
                .key      (key),
                .tag      (tag),
                .run_done (run_done),
                .cand_in  (chain[i]),
                .cand_out (chain[i+1]),
                .awaiting (cell_await[i])
            );
        end
    endgenerate

    // Search once the last awaited run has been served
    assign go_scan = (|load_vec) && ((awaiting & ~load_vec) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (go_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_W'(MAX_RUNS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_fire)
        begin
            state_next    = ST_IDLE;
            scan_cnt_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            if (best.valid)
            begin
                out_key_reg    <= best.key;
                out_tag_reg    <= best.tag;
                from_run_reg   <= best.run;
                merge_done_reg <= 1'b0;
            end
            else
            begin
                out_key_reg    <= '0;
                out_tag_reg    <= '0;
                from_run_reg   <= '0;
                merge_done_reg <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_key    = out_key_reg;
    assign out_tag    = out_tag_reg;
    assign from_run   = from_run_reg;
    assign merge_done = merge_done_reg;

endmodule

// ===== dv/tb_kway_merge_max_first.sv =====
module tb_kway_merge_max_first;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int SETTLE_CYCLES = MAX_RUNS + 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int QUIET_AFTER   = 850;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [RUN_W-1:0] run;
        logic             done;
    } merge_out_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [RUN_W-1:0] run_index;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             run_done;
    logic             out_valid;
    logic             out_ready;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic [RUN_W-1:0] from_run;
    logic             merge_done;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] active_runs;

    // Merge state as the block should hold it
    int                m_runs;
    logic [KEY_W-1:0]  m_key [MAX_RUNS];
    logic [TAG_W-1:0]  m_tag [MAX_RUNS];
    logic              m_live[MAX_RUNS];
    logic [MAX_RUNS-1:0] m_await;

    merge_out_t merged_stream_q[$];
    merge_out_t head_want;
    int         items_taken = 0;
    int         mismatches  = 0;
    int         cycles      = 0;
    bit         bursts_on   = 1'b1;

    kway_merge_max_first u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .run_index   (run_index),
        .key         (key),
        .tag         (tag),
        .run_done    (run_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .from_run    (from_run),
        .merge_done  (merge_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .active_runs (active_runs)
    );

    always #4 clk = ~clk;

    function automatic void merge_restart(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1)
            n = 1;
        if (n > MAX_RUNS)
            n = MAX_RUNS;
        m_runs  = n;
        m_await = '0;
        for (int i = 0; i < MAX_RUNS; i++)
        begin
            m_key[i]  = '0;
            m_tag[i]  = '0;
            m_live[i] = 1'b0;
            if (i < n)
                m_await[i] = 1'b1;
        end
    endfunction

    function automatic void merge_accept(input logic [RUN_W-1:0] r, input logic [KEY_W-1:0] k,
                                         input logic [TAG_W-1:0] t, input logic d);
        int         best;
        merge_out_t res;
        best = -1;
        // drop transactions for runs that are inactive or not awaited
        if (int'(r) >= m_runs || !m_await[r])
            return;
        items_taken++;
        m_await[r] = 1'b0;
        if (!d)
        begin
            m_key[r]  = k;
            m_tag[r]  = t;
            m_live[r] = 1'b1;
        end
        if (m_await != '0)
            return;
        for (int i = 0; i < m_runs; i++)
        begin
            if (m_live[i] && (best < 0 || m_key[i] > m_key[best]))
                best = i;
        end
        if (best < 0)
        begin
            res = '{key: '0, tag: '0, run: '0, done: 1'b1};
        end
        else
        begin
            res = '{key: m_key[best], tag: m_tag[best], run: best[RUN_W-1:0], done: 1'b0};
            m_live[best]  = 1'b0;
            m_await[best] = 1'b1;
        end
        merged_stream_q.push_back(res);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[TAG_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                merge_restart(active_runs);
            if (in_valid && in_ready)
                merge_accept(run_index, key, tag, run_done);
            if (out_valid && out_ready)
            begin
                if (merged_stream_q.size() == 0)
                begin
                    $error("unexpected result: key %h tag %h run %0d done %b",
                           out_key, out_tag, from_run, merge_done);
                    mismatches++;
                end
                else
                begin
                    head_want = merged_stream_q.pop_front();
                    if (out_key !== head_want.key)
                    begin
                        $error("out_key: expected %h, got %h", head_want.key, out_key);
                        mismatches++;
                    end
                    if (out_tag !== head_want.tag)
                    begin
                        $error("out_tag: expected %h, got %h", head_want.tag, out_tag);
                        mismatches++;
                    end
                    if (from_run !== head_want.run)
                    begin
                        $error("from_run: expected %0d, got %0d", head_want.run, from_run);
                        mismatches++;
                    end
                    if (merge_done !== head_want.done)
                    begin
                        $error("merge_done: expected %b, got %b", head_want.done, merge_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("timeout, %0d results still expected", merged_stream_q.size());
            $display("tb_kway_merge_max_first: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts while bursts_on is set
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    // Valid stays high so back-to-back transactions need no second assignment.
    task automatic send_item(input logic [RUN_W-1:0] r, input logic [KEY_W-1:0] k,
                             input logic [TAG_W-1:0] t, input logic d);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        run_index <= r;
        key       <= k;
        tag       <= t;
        run_done  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (merged_stream_q.size() != 0);
    endtask

    task automatic write_run_count(input logic [CFG_W-1:0] v);
        wait_drained();
        // ignored transactions may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid   <= 1'b1;
        active_runs <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Eight runs from reset: extremes, ties, ignored runs, end notices, done result
    task automatic test_reset_merge();
        send_item(0, 32'hFFFF_FFFF, {TAG_W{1'b1}}, 1'b0);
        send_item(0, 32'h0000_1234, 48'h1, 1'b0);
        send_item(1, 32'h0000_0000, '0, 1'b0);
        send_item(2, 32'h8000_0000, 48'h5555_5555_5555, 1'b0);
        send_item(3, 32'h8000_0000, 48'hAAAA_AAAA_AAAA, 1'b0);
        send_item(4, 32'hFFFF_FFFF, {TAG_W{1'b1}}, 1'b1);
        send_item(5, 32'h0F0F_0F0F, 48'h1234_5678_9ABC, 1'b1);
        send_item(6, '0, '0, 1'b1);
        send_item(7, 32'h7FFF_FFFF, rand_tag(), 1'b1);
        wait_drained();
        send_item(0, '0, '0, 1'b1);
        send_item(2, 32'h8000_0000, 48'h0F0F_0F0F_0F0F, 1'b0);
        send_item(2, '0, '0, 1'b1);
        send_item(3, '0, '0, 1'b1);
        send_item(1, '0, '0, 1'b1);
        send_item(5, 32'h0100_0000, rand_tag(), 1'b0);
    endtask

    // Zero reads as one run; out-of-range run index is dropped
    task automatic test_single_run();
        write_run_count(4'd0);
        send_item(3, 32'h0200_0000, rand_tag(), 1'b0);
        send_item(0, 32'h0100_0000, rand_tag(), 1'b0);
        send_item(0, 32'h0080_0000, rand_tag(), 1'b0);
        send_item(0, '0, '0, 1'b1);
    endtask

    task automatic test_random_merges();
        int               base;
        int               phase_no;
        int               r;
        int               step;
        bit               coarse;
        bit               pause_phase;
        logic [CFG_W-1:0] cfg;
        logic [KEY_W-1:0] run_last[MAX_RUNS];
        int               run_left[MAX_RUNS];
        base     = items_taken;
        phase_no = 0;
        while (items_taken - base < RANDOM_ITEMS)
        begin
            case (phase_no)
                0:       cfg = 4'd1;
                1:       cfg = 4'd8;
                2:       cfg = 4'd15;
                3:       cfg = 4'd0;
                4:       cfg = 4'd9;
                default: cfg = CFG_W'($urandom_range(0, 15));
            endcase
            write_run_count(cfg);
            coarse      = ($urandom_range(0, 2) == 0);
            pause_phase = (phase_no % 7 == 3);
            for (int i = 0; i < MAX_RUNS; i++)
            begin
                run_left[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16)
                                                          : $urandom_range(0, 4);
                case ($urandom_range(0, 3))
                    0:       run_last[i] = 32'hFFFF_FFFF;
                    1:       run_last[i] = {2'($urandom_range(0, 3)), 30'h0};
                    default: run_last[i] = $urandom();
                endcase
            end
            while (m_await != '0)
            begin
                bursts_on = (items_taken - base < QUIET_AFTER);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(RUN_W'($urandom_range(0, 7)), $urandom(), rand_tag(),
                              1'($urandom_range(0, 1)));
                end
                else
                begin
                    do
                        r = $urandom_range(0, MAX_RUNS - 1);
                    while (!m_await[r]);
                    if (run_left[r] == 0)
                    begin
                        send_item(RUN_W'(r), $urandom(), rand_tag(), 1'b1);
                    end
                    else
                    begin
                        // keep each run descending; a zero step makes ties
                        if (coarse)
                            step = $urandom_range(0, 1) << 30;
                        else
                            step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 26);
                        if (step > run_last[r])
                            run_last[r] = '0;
                        else
                            run_last[r] = run_last[r] - step;
                        send_item(RUN_W'(r), run_last[r], rand_tag(), 1'b0);
                        run_left[r]--;
                    end
                end
                if (pause_phase && $urandom_range(0, 9) == 0)
                    wait_drained();
            end
            // after the done result everything is dropped
            if ($urandom_range(0, 3) == 0)
                send_item(RUN_W'($urandom_range(0, 7)), $urandom(), rand_tag(),
                          1'($urandom_range(0, 1)));
            phase_no++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        run_index   = '0;
        key         = '0;
        tag         = '0;
        run_done    = 1'b0;
        cfg_valid   = 1'b0;
        active_runs = 4'd8;
        merge_restart(4'd8);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_merge();
        test_single_run();
        test_random_merges();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_kway_merge_max_first: clean");
        else
            $display("tb_kway_merge_max_first: errors");
        $finish;
    end

endmodule
